// ===== hdl/dq_pkg.sv =====
package dq_pkg;

  // Ring depth and the widths that follow from it.
  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = CW + 1;

  localparam int WORD_W = 64;

  // Operation codes on the mode port.
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_REVERSE    = 3'd4;
  localparam logic [2:0] MODE_QUERY      = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic {
    DQ_IDLE,
    DQ_FILL
  } dq_state_t;

  // One request to the word store per cycle: an optional write and a read.
  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic [AW-1:0]     raddr;
  } dq_mem_req_t;

endpackage

// ===== hdl/dq_store.sv =====
module dq_store (
  input  logic                      clk,
  input  dq_pkg::dq_mem_req_t       req,
  output logic [dq_pkg::WORD_W-1:0] rd_data
);
  import dq_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[req.raddr];
  end

endmodule

// ===== hdl/dq_ctrl.sv =====
module dq_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [2:0]                mode,
  input  logic [dq_pkg::WORD_W-1:0] data_value,
  input  logic [dq_pkg::WORD_W-1:0] rd_data,
  output dq_pkg::dq_mem_req_t       req,
  output logic                      busy,
  output logic                      done,
  output logic [dq_pkg::WORD_W-1:0] front_word,
  output logic [dq_pkg::WORD_W-1:0] back_word,
  output logic [dq_pkg::CW-1:0]     entry_count,
  output logic                      is_empty,
  output logic [1:0]                status
);
  import dq_pkg::*;

  dq_state_t         state, state_next;
  logic [AW-1:0]     head, head_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic              rev, rev_next;
  logic              done_next;
  logic [1:0]        status_next;
  logic              fill_front, fill_front_next;
  // Cached copies of the words at the two physical ends.
  logic [WORD_W-1:0] pf, pf_next;
  logic [WORD_W-1:0] pb, pb_next;

  logic          accept;
  logic          is_push;
  logic          at_front;
  logic          full_q;
  logic          empty_q;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] head_dec;
  logic [CW-1:0] off;
  logic [SW-1:0] sum;
  logic [SW-1:0] slot;
  logic [AW-1:0] slot_a;

  assign accept   = start && (state == DQ_IDLE);
  assign is_push  = (mode == MODE_PUSH_FRONT) || (mode == MODE_PUSH_BACK);
  assign at_front = ((mode == MODE_PUSH_FRONT) || (mode == MODE_POP_FRONT)) != rev;
  assign full_q   = (cnt == CW'(DEPTH));
  assign empty_q  = (cnt == '0);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);

  // Slot past the back for a push, slot before the back for a pop.
  assign off    = is_push ? cnt : cnt - CW'(2);
  assign sum    = SW'(head) + SW'(off);
  assign slot   = (sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum;
  assign slot_a = slot[AW-1:0];

  always_comb begin
    state_next      = state;
    head_next       = head;
    cnt_next        = cnt;
    rev_next        = rev;
    pf_next         = pf;
    pb_next         = pb;
    status_next     = status;
    fill_front_next = fill_front;
    done_next       = 1'b0;
    req.we          = 1'b0;
    req.waddr       = slot_a;
    req.wdata       = data_value;
    req.raddr       = at_front ? head_inc : slot_a;
    case (state)
      DQ_IDLE: begin
        if (accept) begin
          done_next   = 1'b1;
          status_next = ST_DONE;
          case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              if (full_q) begin
                status_next = ST_FULL;
              end else begin
                req.we   = 1'b1;
                cnt_next = cnt + CW'(1);
                if (at_front) begin
                  head_next = head_dec;
                  req.waddr = head_dec;
                  pf_next   = data_value;
                  if (empty_q) begin
                    pb_next = data_value;
                  end
                end else begin
                  pb_next = data_value;
                  if (empty_q) begin
                    pf_next = data_value;
                  end
                end
              end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
              if (empty_q) begin
                status_next = ST_EMPTY;
              end else begin
                cnt_next        = cnt - CW'(1);
                fill_front_next = at_front;
                if (at_front) begin
                  head_next = head_inc;
                end
                done_next  = 1'b0;
                state_next = DQ_FILL;
              end
            end
            MODE_REVERSE: begin
              rev_next = ~rev;
            end
            default: begin
            end
          endcase
        end
      end
      DQ_FILL: begin
        if (fill_front) begin
          pf_next = rd_data;
        end else begin
          pb_next = rd_data;
        end
        done_next  = 1'b1;
        state_next = DQ_IDLE;
      end
      default: begin
        state_next = DQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DQ_IDLE;
      head  <= '0;
      cnt   <= '0;
      rev   <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      cnt   <= cnt_next;
      rev   <= rev_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    pf         <= pf_next;
    pb         <= pb_next;
    status     <= status_next;
    fill_front <= fill_front_next;
  end

  assign busy        = (state != DQ_IDLE);
  assign entry_count = cnt;
  assign is_empty    = empty_q;
  assign front_word  = empty_q ? '0 : (rev ? pb : pf);
  assign back_word   = empty_q ? '0 : (rev ? pf : pb);

endmodule

// ===== hdl/double_ended_queue_unit.sv =====
// Bounded double-ended queue of 64-bit words kept in a ring buffer.
//
// Command channel: a word (mode, data_value) is taken at a rising edge where
// start is high and busy is low. Modes push at the front or back, pop the
// front or back, reverse the order, or only query; unused codes act as query.
// Result channel: done is high for exactly one cycle, and during that cycle
// front_word, back_word, entry_count, is_empty and status describe the queue
// after the operation. The receiver cannot hold a result off; it must take it.
// Timing: push, reverse, query and any refused operation give their result
// in the cycle after acceptance, and a new word may be issued in that same
// cycle, so they run at one word per cycle. A successful pop goes through
// the fill state to fetch the word that becomes the new end from the
// single-read-port store, whose read is registered; busy is high meanwhile.
// Reset (synchronous, active high) empties the queue, clears the direction
// flag and the head pointer; the store itself is not cleared, since a stale
// word read from it is never shown: both end words read as zero when empty.
module double_ended_queue_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                mode,
  input  logic [dq_pkg::WORD_W-1:0] data_value,
  output logic                      done,
  output logic [dq_pkg::WORD_W-1:0] front_word,
  output logic [dq_pkg::WORD_W-1:0] back_word,
  output logic [dq_pkg::CW-1:0]     entry_count,
  output logic                      is_empty,
  output logic [1:0]                status
);
  import dq_pkg::*;

  dq_mem_req_t       req;
  logic [WORD_W-1:0] rd_data;

  // The word store holds the queue contents; the controller keeps the head pointer,
  // the count, the direction flag and cached copies of both end words.
  dq_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  dq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .data_value  (data_value),
    .rd_data     (rd_data),
    .req         (req),
    .busy        (busy),
    .done        (done),
    .front_word  (front_word),
    .back_word   (back_word),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .status      (status)
  );

  // A result is never shown while a fetch is still outstanding.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // The count never exceeds the ring depth.
  assert property (@(posedge clk) disable iff (rst) entry_count <= CW'(DEPTH))
    else $error("count beyond depth");

  // Every accepted word yields a result next cycle or starts a fetch.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done || busy)
    else $error("accepted word produced no result");

  // A successful pop always goes through the fetch cycle.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy && !is_empty &&
    (mode == MODE_POP_FRONT || mode == MODE_POP_BACK) |=> busy ##1 done)
    else $error("pop did not fetch the new end word");

endmodule
